[rtl/core/at_response_line_classifier_core_assert.svh]
// ----------------------------------------------------------------------------
// AT response line classifier - assertion macros
// Shared concurrent assertion helpers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef AT_RESPONSE_LINE_CLASSIFIER_CORE_ASSERT_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define ATRLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atrlc: same-cycle check failed");

// next-cycle implication
`define ATRLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atrlc: next-cycle check failed");

`endif

[rtl/core/atrlc_pkg.sv]
// ----------------------------------------------------------------------------
// AT response line classifier - package
// Widths, character codes, result codes and the pattern match tables.
// ----------------------------------------------------------------------------
`default_nettype none

package atrlc_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = 7;
    localparam int PAT_COUNT     = 5;
    localparam int PAT_MAX       = 14;
    localparam int PROG_W        = $clog2(PAT_MAX + 1);

    typedef logic [7:0]        t_byte;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [PROG_W-1:0] t_prog;

    typedef enum logic [3:0] {
        LT_NONE      = 4'd0,
        LT_OK        = 4'd1,
        LT_ERROR     = 4'd2,
        LT_FAIL      = 4'd3,
        LT_SEND_OK   = 4'd4,
        LT_WIFI_CONN = 4'd5,
        LT_WIFI_IP   = 4'd6,
        LT_OTHER     = 4'd7,
        LT_PROMPT    = 4'd8
    } t_line_kind;

    typedef struct packed {
        t_line_kind line_kind;
        t_len       line_length;
    } t_result;

    localparam t_byte CH_NUL    = 8'h00;
    localparam t_byte CH_LF     = 8'h0A;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_PROMPT = 8'h3E;
    localparam t_byte CH_O      = 8'h4F;
    localparam t_byte CH_K      = 8'h4B;

    // pattern ids, also the bit positions of the found flags (priority order)
    localparam int PAT_ERROR     = 0;
    localparam int PAT_FAIL      = 1;
    localparam int PAT_SEND_OK   = 2;
    localparam int PAT_WIFI_CONN = 3;
    localparam int PAT_WIFI_IP   = 4;

    localparam logic [8*PAT_MAX-1:0] TXT_ERROR     = "ERROR";
    localparam logic [8*PAT_MAX-1:0] TXT_FAIL      = "FAIL";
    localparam logic [8*PAT_MAX-1:0] TXT_SEND_OK   = "SEND OK";
    localparam logic [8*PAT_MAX-1:0] TXT_WIFI_CONN = "WIFI CONNECTED";
    localparam logic [8*PAT_MAX-1:0] TXT_WIFI_IP   = "WIFI GOT IP";

    function automatic int pat_len(input int p);
        case (p)
            PAT_ERROR:     return 5;
            PAT_FAIL:      return 4;
            PAT_SEND_OK:   return 7;
            PAT_WIFI_CONN: return 14;
            PAT_WIFI_IP:   return 11;
            default:       return 0;
        endcase
    endfunction

    // character i (from the start) of pattern p, zero outside the pattern
    function automatic t_byte pat_char(input int p, input int i);
        logic [8*PAT_MAX-1:0] txt;
        int                   len;
        case (p)
            PAT_ERROR:     txt = TXT_ERROR;
            PAT_FAIL:      txt = TXT_FAIL;
            PAT_SEND_OK:   txt = TXT_SEND_OK;
            PAT_WIFI_CONN: txt = TXT_WIFI_CONN;
            PAT_WIFI_IP:   txt = TXT_WIFI_IP;
            default:       txt = '0;
        endcase
        len = pat_len(p);
        if (i < 0 || i >= len) begin
            return '0;
        end
        return txt[8*(len-1-i) +: 8];
    endfunction

    // True when prefix length k can follow matched length st, given the
    // incoming byte equals character k-1: the first k-1 characters must be
    // a suffix of the st characters already matched. Elaboration time only.
    function automatic bit kmp_ok(input int p, input int st, input int k);
        int len;
        bit ok;
        len = pat_len(p);
        ok  = (k >= 1) && (k <= len) && (k <= st + 1) && (st <= len);
        for (int j = 0; j < PAT_MAX; j++) begin
            if (ok && (j < k - 1) && (pat_char(p, j) != pat_char(p, st - (k - 1) + j))) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

[rtl/core/atrlc_in_if.sv]
// ----------------------------------------------------------------------------
// AT response line classifier - input channel
// Valid/ready channel carrying one received modem byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface atrlc_in_if;
    import atrlc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/atrlc_out_if.sv]
// ----------------------------------------------------------------------------
// AT response line classifier - output channel
// Valid/ready channel carrying one line classification per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface atrlc_out_if;
    import atrlc_pkg::*;

    logic       valid;
    logic       ready;
    t_line_kind line_kind;
    t_len       line_length;

    modport source (output valid, output line_kind, output line_length, input ready);
    modport sink   (input valid, input line_kind, input line_length, output ready);
endinterface

`default_nettype wire

[rtl/core/atrlc_line_tracker.sv]
// ----------------------------------------------------------------------------
// AT response line classifier - line tracker
// Per-pattern match automata, line length and exact-OK state; gives the
// classification of the current byte combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module atrlc_line_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  atrlc_pkg::t_byte  i_data_byte,
    output atrlc_pkg::t_result o_result
);
    import atrlc_pkg::*;

    typedef enum logic [1:0] {
        OK_EMPTY,
        OK_O,
        OK_MATCH,
        OK_NOT
    } t_ok_state;

    t_count               r_count, n_count;
    logic                 r_zero, n_zero;
    t_ok_state            r_ok, n_ok;
    t_prog                r_prog [PAT_COUNT];
    t_prog                n_prog [PAT_COUNT];
    logic [PAT_COUNT-1:0] r_found, n_found;
    t_prog                w_adv  [PAT_COUNT];

    logic       w_is_prompt, w_is_lf, w_is_cr, w_room;
    t_line_kind w_class;

    // next matched length per pattern: highest k whose predecessor prefix fits
    for (genvar gp = 0; gp < PAT_COUNT; gp++) begin : g_pat
        logic [PAT_MAX:1] w_cand;
        t_prog            w_next;

        for (genvar gk = 1; gk <= PAT_MAX; gk++) begin : g_k
            localparam t_byte Ch = pat_char(gp, gk - 1);
            logic [PAT_MAX:0] w_ok_st;
            for (genvar gs = 0; gs <= PAT_MAX; gs++) begin : g_s
                localparam bit Ok = kmp_ok(gp, gs, gk);
                assign w_ok_st[gs] = Ok;
            end
            assign w_cand[gk] = w_ok_st[r_prog[gp]] && (i_data_byte == Ch);
        end

        always_comb begin
            w_next = '0;
            for (int k = 1; k <= PAT_MAX; k++) begin
                if (w_cand[k]) begin
                    w_next = t_prog'(k);
                end
            end
        end

        assign w_adv[gp] = w_next;
    end

    assign w_is_prompt = (i_data_byte == CH_PROMPT);
    assign w_is_lf     = (i_data_byte == CH_LF);
    assign w_is_cr     = (i_data_byte == CH_CR);
    assign w_room      = !r_zero && (r_count < t_count'(LINE_CAPACITY - 1));

    always_comb begin
        if (r_count == '0) begin
            w_class = LT_NONE;
        end else if (r_ok == OK_MATCH) begin
            w_class = LT_OK;
        end else if (r_found[PAT_ERROR]) begin
            w_class = LT_ERROR;
        end else if (r_found[PAT_FAIL]) begin
            w_class = LT_FAIL;
        end else if (r_found[PAT_SEND_OK]) begin
            w_class = LT_SEND_OK;
        end else if (r_found[PAT_WIFI_CONN]) begin
            w_class = LT_WIFI_CONN;
        end else if (r_found[PAT_WIFI_IP]) begin
            w_class = LT_WIFI_IP;
        end else begin
            w_class = LT_OTHER;
        end
    end

    always_comb begin
        if (w_is_prompt) begin
            o_result.line_kind   = LT_PROMPT;
            o_result.line_length = t_len'(1);
        end else if (w_is_lf) begin
            o_result.line_kind   = w_class;
            o_result.line_length = (w_class == LT_NONE) ? '0 : t_len'(r_count);
        end else begin
            o_result.line_kind   = LT_NONE;
            o_result.line_length = '0;
        end
    end

    always_comb begin
        n_count = r_count;
        n_zero  = r_zero;
        n_ok    = r_ok;
        n_prog  = r_prog;
        n_found = r_found;
        if (i_accept) begin
            if (w_is_prompt || w_is_lf) begin
                n_count = '0;
                n_zero  = 1'b0;
                n_ok    = OK_EMPTY;
                n_prog  = '{default: '0};
                n_found = '0;
            end else if (!w_is_cr && w_room) begin
                if (i_data_byte == CH_NUL) begin
                    n_zero = 1'b1;
                end else begin
                    case (r_ok)
                        OK_EMPTY: n_ok = (i_data_byte == CH_O) ? OK_O : OK_NOT;
                        OK_O:     n_ok = (i_data_byte == CH_K) ? OK_MATCH : OK_NOT;
                        default:  n_ok = OK_NOT;
                    endcase
                    for (int p = 0; p < PAT_COUNT; p++) begin
                        n_prog[p] = w_adv[p];
                        if (w_adv[p] == t_prog'(pat_len(p))) begin
                            n_found[p] = 1'b1;
                        end
                    end
                    n_count = r_count + t_count'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_zero  <= 1'b0;
            r_ok    <= OK_EMPTY;
            r_prog  <= '{default: '0};
            r_found <= '0;
        end else begin
            r_count <= n_count;
            r_zero  <= n_zero;
            r_ok    <= n_ok;
            r_prog  <= n_prog;
            r_found <= n_found;
        end
    end

endmodule

`default_nettype wire

[rtl/core/at_response_line_classifier_core.sv]
// An accepted byte's result goes to the output register, or to the skid entry
//   if the sink stalls. One byte per cycle while i_in.ready is high, one
//   result per byte; automata update and classification are combinational.
// A two-entry result buffer (output register plus skid) lets input run on
//   while one result waits; i_in.ready drops only when both are full.
// Reset (i_rst_n low, synchronous): line state cleared, both buffers empty.
// ----------------------------------------------------------------------------
// AT response line classifier - top level
// Classifies modem response lines byte by byte into OK / ERROR / FAIL /
// SEND OK / WIFI CONNECTED / WIFI GOT IP / other, and reports '>' prompts.
// ----------------------------------------------------------------------------
`default_nettype none

module at_response_line_classifier_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    atrlc_in_if.sink           i_in,
    atrlc_out_if.source        o_out
);
    import atrlc_pkg::*;

    // combinational result for the byte on the input channel
    t_result w_res;
    logic    w_acc;
    logic    w_take;

    // output register and skid entry
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign i_in.ready = !r_skid_valid;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_take     = r_out_valid && o_out.ready;

    // line state only advances on an accepted transaction
    atrlc_line_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_acc),
        .i_data_byte (i_in.data_byte),
        .o_result    (w_res)
    );

    // Output buffering. Order is kept: the skid entry is always older than
    // any newly accepted result, and the input stalls while it is occupied,
    // so at most one new result can arrive per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_take) begin
                if (r_skid_valid) begin
                    // skid moves up; input was stalled this cycle
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else if (w_acc) begin
                    r_out <= w_res;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_acc) begin
                if (!r_out_valid) begin
                    r_out       <= w_res;
                    r_out_valid <= 1'b1;
                end else begin
                    // sink is stalling: park the new result
                    r_skid       <= w_res;
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.line_kind   = r_out.line_kind;
    assign o_out.line_length = r_out.line_length;

endmodule

`default_nettype wire

[rtl/core/atrlc_checker.sv]
// ----------------------------------------------------------------------------
// AT response line classifier - port checker
// Concurrent checks on the top level's channel ports, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "at_response_line_classifier_core_assert.svh"

module atrlc_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [3:0]       i_out_type,
    input  atrlc_pkg::t_len  i_out_len
);
    import atrlc_pkg::*;

    // a stalled result keeps its payload
    `ATRLC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_type) && $stable(i_out_len))

    // an empty output register is refilled by the next accepted byte
    `ATRLC_ASSERT_NEXT(a_acc_fills, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_out_valid, i_out_valid)

    // input stalls only when a result is waiting
    `ATRLC_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, !i_in_ready, i_out_valid)

    // no-line results carry no length, prompts carry one
    `ATRLC_ASSERT_IMPLY(a_none_len, i_clk, i_rst_n, i_out_valid && (i_out_type == LT_NONE), i_out_len == '0)
    `ATRLC_ASSERT_IMPLY(a_prompt_len, i_clk, i_rst_n, i_out_valid && (i_out_type == LT_PROMPT), i_out_len == t_len'(1))

endmodule

bind at_response_line_classifier_core atrlc_checker u_atrlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_type  (o_out.line_kind),
    .i_out_len   (o_out.line_length)
);

`default_nettype wire
